// ===== hdl/vaa_pkg.sv =====
// shared types, codes, category tables and widths for the voice admission allocator
package vaa_pkg;

  localparam int VOICE_SLOTS_DEFAULT = 32;

  localparam int CATEGORY_COUNT = 18;
  localparam int CAT_W          = 5;
  localparam int POS_W          = 20;
  localparam int SCALE_W        = 16;
  localparam int RADIUS_W       = 13;
  localparam int CAP_W          = 5;
  localparam int SLOT_IDX_W     = 5;
  localparam int STATUS_W       = 3;
  localparam int CFG_ADDR_W     = 2;
  // counter key is {category, focused}
  localparam int KEY_W          = CAT_W + 1;
  localparam int KEY_COUNT      = 2 * CATEGORY_COUNT;
  // |dy| in Q.8 at or above 2^29 is beyond every radius
  localparam int DY_LIMIT_BIT   = 29;
  // dx and dz are taken times 256, so their squares gain 16 bits
  localparam int Q_SHIFT        = 16;

  typedef enum logic [1:0] {
    OP_POST      = 2'd0,
    OP_LISTENER  = 2'd1,
    OP_VOICE_END = 2'd2,
    OP_STOP_ALL  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLAYED    = 3'd0,
    ST_CULLED    = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_NO_SAMPLE = 3'd3,
    ST_DONE      = 3'd4
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HEARING_SCALE  = 2'd0,
    CFG_VERTICAL_SCALE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic stage1;
    logic stage2;
    logic commit;
  } ctrl_cmd_t;

  localparam logic [RADIUS_W-1:0] CAT_RADIUS [CATEGORY_COUNT] = '{
    13'd5020, 13'd0,    13'd0,    13'd1248, 13'd1248, 13'd1248,
    13'd1248, 13'd1000, 13'd1248, 13'd1248, 13'd1248, 13'd1248,
    13'd1000, 13'd1000, 13'd2512, 13'd1600, 13'd1248, 13'd500
  };

  localparam logic [CAP_W-1:0] CAT_CAP_WORLD [CATEGORY_COUNT] = '{
    5'd20, 5'd16, 5'd1, 5'd4, 5'd4, 5'd16, 5'd8, 5'd16, 5'd8,
    5'd8,  5'd16, 5'd16, 5'd8, 5'd4, 5'd8, 5'd8, 5'd12, 5'd16
  };

  localparam logic [CAP_W-1:0] CAT_CAP_PLAYER [CATEGORY_COUNT] = '{
    5'd20, 5'd16, 5'd1, 5'd4, 5'd2, 5'd4, 5'd4, 5'd4, 5'd4,
    5'd4,  5'd4,  5'd4, 5'd3, 5'd2, 5'd4, 5'd4, 5'd2, 5'd2
  };

  // unknown categories have radius zero
  function automatic logic [RADIUS_W-1:0] cat_radius(input logic [CAT_W-1:0] cat);
    logic [RADIUS_W-1:0] r;
    r = '0;
    if (int'(cat) < CATEGORY_COUNT) r = CAT_RADIUS[cat];
    return r;
  endfunction

  // unknown categories have both caps zero
  function automatic logic [CAP_W-1:0] cat_cap(input logic [CAT_W-1:0] cat,
                                                input logic foc);
    logic [CAP_W-1:0] c;
    c = '0;
    if (int'(cat) < CATEGORY_COUNT) c = foc ? CAT_CAP_PLAYER[cat] : CAT_CAP_WORLD[cat];
    return c;
  endfunction

endpackage

// ===== hdl/vaa_ctrl.sv =====
// sequencing state machine of the voice admission allocator
module vaa_ctrl import vaa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd_o,
  output logic      done_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MUL    = 4'b0010,
    S_SQR    = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_MUL;
      S_MUL:    state_d = S_SQR;
      S_SQR:    state_d = S_DECIDE;
      S_DECIDE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_DECIDE);
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign cmd_o.load   = (state_q == S_IDLE) && start;
  assign cmd_o.stage1 = (state_q == S_MUL);
  assign cmd_o.stage2 = (state_q == S_SQR);
  assign cmd_o.commit = (state_q == S_DECIDE);
  assign done_o       = done_q;

endmodule

// ===== hdl/vaa_dist.sv =====
// two-stage multiplier pipeline for the listener distance test
module vaa_dist import vaa_pkg::*; (
  input  logic                clk_i,
  input  logic                stage1_i,
  input  logic                stage2_i,
  input  logic [POS_W-1:0]    pos_x_i,
  input  logic [POS_W-1:0]    pos_y_i,
  input  logic [POS_W-1:0]    pos_z_i,
  input  logic [POS_W-1:0]    lis_x_i,
  input  logic [POS_W-1:0]    lis_y_i,
  input  logic [POS_W-1:0]    lis_z_i,
  input  logic [SCALE_W-1:0]  vscale_i,
  input  logic [SCALE_W-1:0]  hscale_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output logic                too_far_o
);

  localparam int D_W   = POS_W + 1;
  localparam int SQ_W  = 2 * D_W;
  localparam int AY_W  = D_W + SCALE_W;
  localparam int R_W   = RADIUS_W + SCALE_W;
  localparam int LIM_W = DY_LIMIT_BIT;
  localparam int SQ2_W = 2 * LIM_W;
  localparam int RR_W  = 2 * R_W;
  localparam int PS_W  = SQ_W + Q_SHIFT + 1;
  localparam int SUM_W = ((PS_W > SQ2_W) ? PS_W : SQ2_W) + 1;

  logic [D_W-1:0]   dx, dy, dz, mx, my, mz;
  logic [SQ_W-1:0]  mx2, mz2;
  logic [AY_W-1:0]  ay;
  logic [R_W-1:0]   r;

  logic [SQ_W-1:0]  mx2_q, mz2_q;
  logic [AY_W-1:0]  ay_q;
  logic [R_W-1:0]   r_q;

  logic             far_y_q;
  logic [SQ2_W-1:0] ay2_q;
  logic [RR_W-1:0]  r2_q;
  logic [PS_W-1:0]  psum_q;
  logic [LIM_W-1:0] ay_lo;
  logic [SUM_W-1:0] sum;

  // sign-extended differences and their magnitudes
  assign dx = {pos_x_i[POS_W-1], pos_x_i} - {lis_x_i[POS_W-1], lis_x_i};
  assign dy = {pos_y_i[POS_W-1], pos_y_i} - {lis_y_i[POS_W-1], lis_y_i};
  assign dz = {pos_z_i[POS_W-1], pos_z_i} - {lis_z_i[POS_W-1], lis_z_i};
  assign mx = dx[D_W-1] ? (~dx + 1'b1) : dx;
  assign my = dy[D_W-1] ? (~dy + 1'b1) : dy;
  assign mz = dz[D_W-1] ? (~dz + 1'b1) : dz;

  assign mx2 = mx * mx;
  assign mz2 = mz * mz;
  assign ay  = my * vscale_i;
  assign r   = radius_i * hscale_i;

  always_ff @(posedge clk_i) begin
    if (stage1_i) begin
      mx2_q <= mx2;
      mz2_q <= mz2;
      ay_q  <= ay;
      r_q   <= r;
    end
  end

  assign ay_lo = ay_q[LIM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (stage2_i) begin
      far_y_q <= |ay_q[AY_W-1:LIM_W];
      ay2_q   <= ay_lo * ay_lo;
      r2_q    <= r_q * r_q;
      psum_q  <= {1'b0, mx2_q, {Q_SHIFT{1'b0}}} + {1'b0, mz2_q, {Q_SHIFT{1'b0}}};
    end
  end

  assign sum       = SUM_W'(psum_q) + SUM_W'(ay2_q);
  assign too_far_o = far_y_q || (sum > SUM_W'(r2_q));

endmodule

// ===== hdl/vaa_datapath.sv =====
// slot state, per-category voice counters, distance unit and decision logic
module vaa_datapath import vaa_pkg::*; #(
  parameter int VOICE_SLOTS = VOICE_SLOTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  input  logic [1:0]            op_i,
  input  logic [CAT_W-1:0]      category_i,
  input  logic                  focused_i,
  input  logic                  positional_i,
  input  logic                  sample_ready_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [POS_W-1:0]      pos_z_i,
  input  logic [SLOT_IDX_W-1:0] slot_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [SCALE_W-1:0]    cfg_wdata_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_IDX_W-1:0] slot_o,
  output logic                  stolen_o
);

  localparam int SLOT_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int GRP    = 16;
  localparam int GRP_W  = 4;
  localparam int NGRP   = (VOICE_SLOTS + GRP - 1) / GRP;

  // transaction fields held for the whole operation
  op_e                   op_q;
  logic [CAT_W-1:0]      cat_q;
  logic                  foc_q, pos_q, ready_q;
  logic [POS_W-1:0]      px_q, py_q, pz_q;
  logic [SLOT_IDX_W-1:0] sidx_q;

  logic [SCALE_W-1:0]    hs_q, vs_q;
  logic [POS_W-1:0]      lx_q, ly_q, lz_q;

  logic [VOICE_SLOTS-1:0] busy_q, busy_d;
  logic [CNT_W-1:0]       cnt_q [KEY_COUNT];
  logic [CNT_W-1:0]       cnt_d [KEY_COUNT];
  logic [KEY_W-1:0]       key_mem [VOICE_SLOTS];

  logic [NGRP-1:0]        grp_any, grp_any_q;
  logic [GRP_W-1:0]       grp_idx [NGRP];
  logic [GRP_W-1:0]       grp_idx_q [NGRP];
  logic [CNT_W-1:0]       count_q;
  logic [KEY_W-1:0]       old_key_q;

  logic [RADIUS_W-1:0]    radius;
  logic [CAP_W-1:0]       cap;
  logic                   too_far;
  logic                   pos_eff;
  logic [KEY_W-1:0]       new_key;
  logic [SLOT_W-1:0]      rd_addr, sidx_slot, pick;
  logic                   found, sidx_ok, play, vend_busy;
  logic [STATUS_W-1:0]    status_d;

  logic [STATUS_W-1:0]    status_q;
  logic [SLOT_IDX_W-1:0]  slot_q;
  logic                   stolen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      cat_q   <= category_i;
      foc_q   <= focused_i;
      pos_q   <= positional_i;
      ready_q <= sample_ready_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      pz_q    <= pos_z_i;
      sidx_q  <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= SCALE_W'(256);
      vs_q <= SCALE_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_HEARING_SCALE:  hs_q <= cfg_wdata_i;
        CFG_VERTICAL_SCALE: vs_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign radius  = cat_radius(cat_q);
  assign cap     = cat_cap(cat_q, foc_q);
  assign pos_eff = pos_q && (radius != '0);
  assign new_key = {cat_q, foc_q};

  vaa_dist u_dist (
    .clk_i     (clk_i),
    .stage1_i  (cmd_i.stage1),
    .stage2_i  (cmd_i.stage2),
    .pos_x_i   (px_q),
    .pos_y_i   (py_q),
    .pos_z_i   (pz_q),
    .lis_x_i   (lx_q),
    .lis_y_i   (ly_q),
    .lis_z_i   (lz_q),
    .vscale_i  (vs_q),
    .hscale_i  (hs_q),
    .radius_i  (radius),
    .too_far_o (too_far)
  );

  // lowest free slot, first within groups of sixteen
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = 1'b0;
      grp_idx[g] = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (g * GRP + k < VOICE_SLOTS) begin
          if (!busy_q[g * GRP + k]) begin
            grp_any[g] = 1'b1;
            grp_idx[g] = GRP_W'(k);
          end
        end
      end
    end
  end

  assign sidx_ok   = int'(sidx_q) < VOICE_SLOTS;
  assign sidx_slot = SLOT_W'(sidx_q);
  assign rd_addr   = (op_q == OP_VOICE_END) ? sidx_slot : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage1) begin
      grp_any_q <= grp_any;
      for (int g = 0; g < NGRP; g++) grp_idx_q[g] <= grp_idx[g];
      count_q   <= (int'(cat_q) < CATEGORY_COUNT) ? cnt_q[new_key] : '0;
      old_key_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && play) key_mem[pick] <= new_key;
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found = 1'b1;
        pick  = SLOT_W'(g * GRP + int'(grp_idx_q[g]));
      end
    end
  end

  // decision order: distance, cap, sample, then slot grant
  always_comb begin
    play      = 1'b0;
    vend_busy = 1'b0;
    status_d  = ST_DONE;
    unique case (op_q)
      OP_POST: begin
        if (pos_eff && too_far)                      status_d = ST_CULLED;
        else if (CMP_W'(count_q) >= CMP_W'(cap))     status_d = ST_DROPPED;
        else if (!ready_q)                           status_d = ST_NO_SAMPLE;
        else begin
          status_d = ST_PLAYED;
          play     = 1'b1;
        end
      end
      OP_VOICE_END: vend_busy = sidx_ok && busy_q[sidx_slot];
      OP_LISTENER, OP_STOP_ALL: ;
      default: ;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (play) busy_d[pick] = 1'b1;
    if (vend_busy) busy_d[sidx_slot] = 1'b0;
    if (op_q == OP_STOP_ALL) busy_d = '0;
  end

  always_comb begin
    for (int e = 0; e < KEY_COUNT; e++) begin
      logic inc, dec;
      inc = play && (new_key == KEY_W'(e));
      dec = ((play && !found) || vend_busy) && (old_key_q == KEY_W'(e));
      cnt_d[e] = cnt_q[e] + CNT_W'(inc) - CNT_W'(dec);
      if (op_q == OP_STOP_ALL) cnt_d[e] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      for (int e = 0; e < KEY_COUNT; e++) cnt_q[e] <= '0;
      lx_q   <= '0;
      ly_q   <= '0;
      lz_q   <= '0;
    end else if (cmd_i.commit) begin
      busy_q <= busy_d;
      for (int e = 0; e < KEY_COUNT; e++) cnt_q[e] <= cnt_d[e];
      if (op_q == OP_LISTENER) begin
        lx_q <= px_q;
        ly_q <= py_q;
        lz_q <= pz_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      slot_q   <= play ? SLOT_IDX_W'(pick) : '0;
      stolen_q <= play && !found;
    end
  end

  assign status_o = status_q;
  assign slot_o   = slot_q;
  assign stolen_o = stolen_q;

endmodule

// ===== hdl/voice_admission_allocator_unit.sv =====
// top level of the voice admission allocator: controller plus datapath
// One transaction is taken when start is high and busy is low. It runs
// through the accept edge, one multiply stage (offsets times themselves,
// vertical scale and radius scale), one squaring stage, and one decision
// step; the result is then on status_o, slot_o and stolen_o for the single
// cycle in which done_o is high, and the next transaction may be started in
// that same cycle, so no new transaction is taken while one is in flight.
// The receiver cannot hold a result off: sample it when done_o is high.
// Configuration writes (hearing scale, vertical scale) take effect at once
// and must only be issued while busy is low and no result is pending.
module voice_admission_allocator_unit import vaa_pkg::*; #(
  parameter int VOICE_SLOTS = VOICE_SLOTS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            op_i,
  input  logic [CAT_W-1:0]      category_i,
  input  logic                  focused_i,
  input  logic                  positional_i,
  input  logic                  sample_ready_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [POS_W-1:0]      pos_z_i,
  input  logic [SLOT_IDX_W-1:0] slot_index_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [SCALE_W-1:0]    cfg_wdata_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_IDX_W-1:0] slot_o,
  output logic                  stolen_o
);

  // step commands from the sequencer to the datapath
  ctrl_cmd_t cmd;

  // idle, multiply, square, decide
  vaa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // slot busy bits, per category and column voice counters, slot key memory,
  // listener position, scale registers and the distance pipeline
  vaa_datapath #(
    .VOICE_SLOTS (VOICE_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .category_i     (category_i),
    .focused_i      (focused_i),
    .positional_i   (positional_i),
    .sample_ready_i (sample_ready_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .slot_index_i   (slot_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .stolen_o       (stolen_o)
  );

endmodule

// ===== tb/sv/voice_admission_allocator_unit_tb.sv =====
// self-checking testbench for the voice admission allocator unit
`timescale 1ns / 100ps

module voice_admission_allocator_unit_tb;
  import vaa_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int NUM_VOICES = 32;
  localparam int NUM_CATS = 18;
  // idle clocks after the last admission has come back
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES = 5;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int BURST_LEN = 40;
  localparam int GAP_PERCENT = 12;
  localparam longint TIMEOUT_NS = 3_000_000;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam longint unsigned DY_CEILING = 64'd1 << DY_LIMIT_BIT;

  // hearing radius and polyphony caps per category, in table order
  localparam int unsigned CAT_RANGE [NUM_CATS] = '{
    5020, 0, 0, 1248, 1248, 1248, 1248, 1000, 1248,
    1248, 1248, 1248, 1000, 1000, 2512, 1600, 1248, 500
  };
  localparam int unsigned WORLD_LIMIT [NUM_CATS] = '{
    20, 16, 1, 4, 4, 16, 8, 16, 8, 8, 16, 16, 8, 4, 8, 8, 12, 16
  };
  localparam int unsigned PLAYER_LIMIT [NUM_CATS] = '{
    20, 16, 1, 4, 2, 4, 4, 4, 4, 4, 4, 4, 3, 2, 4, 4, 2, 2
  };

  // categories with large world caps, used to fill every voice and force steals
  localparam int unsigned FILL_CATS [5] = '{0, 1, 5, 7, 10};

  typedef struct packed {
    op_e                   op;
    logic [CAT_W-1:0]      category;
    logic                  focused;
    logic                  positional;
    logic                  sample_ready;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [POS_W-1:0]      pos_z;
    logic [SLOT_IDX_W-1:0] slot_index;
  } sound_event_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  stolen;
  } admission_t;

  // clock, reset and block inputs, driven to known values from time zero
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            op_i = '0;
  logic [CAT_W-1:0]      category_i = '0;
  logic                  focused_i = 1'b0;
  logic                  positional_i = 1'b0;
  logic                  sample_ready_i = 1'b0;
  logic [POS_W-1:0]      pos_x_i = '0;
  logic [POS_W-1:0]      pos_y_i = '0;
  logic [POS_W-1:0]      pos_z_i = '0;
  logic [SLOT_IDX_W-1:0] slot_index_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [SCALE_W-1:0]    cfg_wdata_i = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_IDX_W-1:0] slot_o;
  logic                  stolen_o;

  voice_admission_allocator_unit #(
    .VOICE_SLOTS(NUM_VOICES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .category_i     (category_i),
    .focused_i      (focused_i),
    .positional_i   (positional_i),
    .sample_ready_i (sample_ready_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .slot_index_i   (slot_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .stolen_o       (stolen_o)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // events waiting to be sent, and admissions waiting to come back
  sound_event_t pending_q [$];
  admission_t   admission_q [$];

  int  mismatches = 0;
  bit  gaps_on = 1'b1;
  // high when the transaction on the ports was taken at the last rising edge
  logic handed_over = 1'b0;

  // shadow copy of the allocator state
  logic [SCALE_W-1:0] hear_q88;
  logic [SCALE_W-1:0] vert_q88;
  bit                 voice_busy [NUM_VOICES];
  logic [CAT_W-1:0]   voice_cat [NUM_VOICES];
  bit                 voice_foc [NUM_VOICES];
  longint             ear_x, ear_y, ear_z;

  // listener position as the stimulus generator last set it
  int gen_x = 0, gen_y = 0, gen_z = 0;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // admission decision for one event, updating the shadow state as the block would
  function automatic admission_t predict_admission(input sound_event_t ev);
    admission_t           res;
    int unsigned          radius, cap, held, pick;
    bit                   in_range, found;
    longint               dx, dy, dz;
    longint unsigned      ax, ay, az, reach;
    res.status = ST_DONE;
    res.slot = '0;
    res.stolen = 1'b0;
    case (ev.op)
      OP_POST: begin
        radius = 0;
        cap = 0;
        // unknown categories keep radius and caps at zero
        if (ev.category < NUM_CATS) begin
          radius = CAT_RANGE[ev.category];
          cap = ev.focused ? PLAYER_LIMIT[ev.category] : WORLD_LIMIT[ev.category];
        end
        held = 0;
        for (int i = 0; i < NUM_VOICES; i++)
          if (voice_busy[i] && voice_cat[i] == ev.category && voice_foc[i] == ev.focused)
            held++;
        // zero-radius categories are never placed, so never culled
        in_range = 1'b1;
        if (ev.positional && radius != 0) begin
          dx = longint'($signed(ev.pos_x)) - ear_x;
          dy = longint'($signed(ev.pos_y)) - ear_y;
          dz = longint'($signed(ev.pos_z)) - ear_z;
          ax = longint'(dx < 0 ? -dx : dx) * 64'd256;
          ay = longint'(dy < 0 ? -dy : dy) * longint'(vert_q88);
          az = longint'(dz < 0 ? -dz : dz) * 64'd256;
          reach = longint'(radius) * longint'(hear_q88);
          // a vertical offset past the ceiling is out of reach of every radius
          in_range = (ay < DY_CEILING) && (ax * ax + ay * ay + az * az <= reach * reach);
        end
        if (!in_range) begin
          res.status = ST_CULLED;
        end else if (held >= cap) begin
          res.status = ST_DROPPED;
        end else if (!ev.sample_ready) begin
          res.status = ST_NO_SAMPLE;
        end else begin
          found = 1'b0;
          pick = 0;
          for (int i = 0; i < NUM_VOICES; i++)
            if (!found && !voice_busy[i]) begin
              pick = i;
              found = 1'b1;
            end
          // all voices busy: slot 0 is taken over
          res.stolen = !found;
          voice_busy[pick] = 1'b1;
          voice_cat[pick] = ev.category;
          voice_foc[pick] = ev.focused;
          res.status = ST_PLAYED;
          res.slot = SLOT_IDX_W'(pick);
        end
      end
      OP_LISTENER: begin
        ear_x = longint'($signed(ev.pos_x));
        ear_y = longint'($signed(ev.pos_y));
        ear_z = longint'($signed(ev.pos_z));
      end
      OP_VOICE_END: begin
        if (ev.slot_index < NUM_VOICES) voice_busy[ev.slot_index] = 1'b0;
      end
      default: begin
        // stop all frees every voice but keeps category and column
        for (int i = 0; i < NUM_VOICES; i++) voice_busy[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  function automatic sound_event_t make_event(input op_e op, input int cat, input bit foc,
                                              input bit posl, input bit rdy, input int x,
                                              input int y, input int z, input int sidx);
    sound_event_t ev;
    ev.op = op;
    ev.category = CAT_W'(cat);
    ev.focused = foc;
    ev.positional = posl;
    ev.sample_ready = rdy;
    ev.pos_x = POS_W'(x);
    ev.pos_y = POS_W'(y);
    ev.pos_z = POS_W'(z);
    ev.slot_index = SLOT_IDX_W'(sidx);
    return ev;
  endfunction

  // coordinate around a center: mostly within hearing, sometimes far or anywhere
  function automatic logic [POS_W-1:0] near_coord(input int center);
    int unsigned spread;
    case ($urandom_range(9))
      0, 1, 2, 3: spread = 1500;
      4, 5, 6:    spread = 6000;
      7:          spread = 90000;
      default:    return POS_W'($urandom);
    endcase
    return POS_W'(center + int'($urandom_range(2 * spread)) - int'(spread));
  endfunction

  function automatic sound_event_t random_event();
    sound_event_t ev;
    int unsigned  roll;
    roll = $urandom_range(99);
    if (roll < 66) ev.op = OP_POST;
    else if (roll < 73) ev.op = OP_LISTENER;
    else if (roll < 98) ev.op = OP_VOICE_END;
    else ev.op = OP_STOP_ALL;
    // mostly known categories, the rest anywhere in the field
    ev.category = ($urandom_range(9) < 8) ? CAT_W'($urandom_range(NUM_CATS - 1))
                                          : CAT_W'($urandom);
    ev.focused = 1'($urandom_range(1));
    ev.positional = 1'($urandom_range(1));
    ev.sample_ready = ($urandom_range(9) != 0);
    ev.pos_x = near_coord(gen_x);
    ev.pos_y = near_coord(gen_y);
    ev.pos_z = near_coord(gen_z);
    ev.slot_index = SLOT_IDX_W'($urandom);
    if (ev.op == OP_LISTENER) begin
      gen_x = int'($signed(ev.pos_x));
      gen_y = int'($signed(ev.pos_y));
      gen_z = int'($signed(ev.pos_z));
    end
    return ev;
  endfunction

  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [SCALE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_HEARING_SCALE) hear_q88 = val;
    else if (idx == CFG_VERTICAL_SCALE) vert_q88 = val;
  endtask

  // wait until every event is sent and every admission is back, then let it settle
  task automatic drain_all();
    while (pending_q.size() != 0 || start || admission_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // monitor: check results and record accepted transactions at the rising edge
  always @(posedge clk_i) begin
    admission_t   want;
    sound_event_t seen;
    if (rst_ni) begin
      // the result of an older transaction is checked before a new one is predicted
      if (done_o) begin
        if (admission_q.size() == 0) begin
          flag_mismatch("result with no transaction outstanding", status_o, ST_DONE);
        end else begin
          want = admission_q.pop_front();
          if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
          if (slot_o !== want.slot) flag_mismatch("slot", slot_o, want.slot);
          if (stolen_o !== want.stolen) flag_mismatch("stolen", stolen_o, want.stolen);
        end
      end
      if (start && !busy) begin
        seen.op = op_e'(op_i);
        seen.category = category_i;
        seen.focused = focused_i;
        seen.positional = positional_i;
        seen.sample_ready = sample_ready_i;
        seen.pos_x = pos_x_i;
        seen.pos_y = pos_y_i;
        seen.pos_z = pos_z_i;
        seen.slot_index = slot_index_i;
        admission_q.push_back(predict_admission(seen));
      end
      handed_over <= start && !busy;
    end
  end

  // driver: present the next event at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    sound_event_t nxt;
    if (rst_ni && (!start || handed_over)) begin
      if (pending_q.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PERCENT)) begin
        nxt = pending_q.pop_front();
        op_i <= nxt.op;
        category_i <= nxt.category;
        focused_i <= nxt.focused;
        positional_i <= nxt.positional;
        sample_ready_i <= nxt.sample_ready;
        pos_x_i <= nxt.pos_x;
        pos_y_i <= nxt.pos_y;
        pos_z_i <= nxt.pos_z;
        slot_index_i <= nxt.slot_index;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    logic [SCALE_W-1:0] hs, vs;
    // shadow state at reset
    hear_q88 = 16'd256;
    vert_q88 = 16'd256;
    ear_x = 0;
    ear_y = 0;
    ear_z = 0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_busy[i] = 1'b0;
      voice_cat[i] = '0;
      voice_foc[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset scales and listener at the origin
    // near positional post, then far on the x axis
    pending_q.push_back(make_event(OP_POST, 0, 0, 1, 1, 100, -100, 100, 0));
    pending_q.push_back(make_event(OP_POST, 0, 0, 1, 1, 524287, 0, 0, 0));
    // zero-radius category far away is still played
    pending_q.push_back(make_event(OP_POST, 1, 0, 1, 1, -524288, -524288, -524288, 0));
    // cap of one: second post in the same column is dropped, other column has no sample
    pending_q.push_back(make_event(OP_POST, 2, 0, 0, 1, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_POST, 2, 0, 0, 1, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_POST, 2, 1, 0, 0, 0, 0, 0, 0));
    // unknown categories have both caps zero, so their posts are dropped
    pending_q.push_back(make_event(OP_POST, 18, 0, 0, 1, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_POST, 31, 1, 1, 1, -1, -1, -1, 31));
    pending_q.push_back(make_event(OP_POST, 17, 1, 1, 1, 0, 524287, 0, 0));
    // listener at the corner, emitters inside, exactly on and just past the radius
    pending_q.push_back(make_event(OP_LISTENER, 0, 0, 0, 0, 524287, -524288, 524287, 0));
    pending_q.push_back(make_event(OP_POST, 14, 0, 1, 1, 523287, -523788, 524287, 0));
    pending_q.push_back(make_event(OP_POST, 14, 0, 1, 1, 521775, -524288, 524287, 0));
    pending_q.push_back(make_event(OP_POST, 14, 0, 1, 1, 521774, -524288, 524287, 0));
    // voice ended on a busy slot, the same slot again, and a free slot
    pending_q.push_back(make_event(OP_VOICE_END, 0, 0, 0, 0, 0, 0, 0, 3));
    pending_q.push_back(make_event(OP_VOICE_END, 0, 0, 0, 0, 0, 0, 0, 3));
    pending_q.push_back(make_event(OP_VOICE_END, 0, 0, 0, 0, 0, 0, 0, 31));
    // freed slot is the lowest free one
    pending_q.push_back(make_event(OP_POST, 5, 0, 0, 1, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_STOP_ALL, 31, 1, 1, 1, -1, -1, -1, 31));
    pending_q.push_back(make_event(OP_POST, 2, 0, 0, 1, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_LISTENER, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_POST, 3, 1, 1, 1, 0, 0, 0, 0));
    pending_q.push_back(make_event(OP_POST, 16, 1, 1, 1, 1000, 0, -1000, 0));
    drain_all();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          // zero hearing scale: every positional post off the listener with a nonzero radius is culled
          hs = '0;
          vs = 16'd256;
        end
        1: begin
          // largest scales reach the vertical ceiling at modest offsets
          hs = '1;
          vs = '1;
        end
        2: begin
          hs = 16'd256;
          vs = '0;
        end
        3: begin
          hs = 16'd96;
          vs = 16'd1024;
        end
        default: begin
          hs = SCALE_W'($urandom_range(65535, 1));
          vs = SCALE_W'($urandom);
        end
      endcase
      write_cfg(CFG_HEARING_SCALE, hs);
      write_cfg(CFG_VERTICAL_SCALE, vs);
      write_cfg((ph % 2 == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, SCALE_W'($urandom));
      @(negedge clk_i);
      cfg_we_i <= 1'b0;

      // one phase runs with no sender gaps at all
      gaps_on = (ph != 2);
      // fill every voice so later posts steal slot 0
      for (int n = 0; n < BURST_LEN; n++)
        pending_q.push_back(make_event(OP_POST, FILL_CATS[$urandom_range(4)],
                                       ($urandom_range(3) == 0), 0, 1,
                                       $urandom, $urandom, $urandom, $urandom));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) pending_q.push_back(random_event());
      // the sender holds off here until every admission has come back
      drain_all();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
